// ===== sv/als_pkg.sv =====
// shared types and constants of the array literal splitter
`timescale 1ns / 1ps
`default_nettype none
package als_pkg;

    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 32;
    localparam int KIND_BITS     = 3;
    localparam int ECNT_BITS     = 16;

    typedef enum logic [2:0] {
        KIND_BYTE      = 3'd0,
        KIND_DISCARD   = 3'd1,
        KIND_ELEM_END  = 3'd2,
        KIND_ARRAY_END = 3'd3,
        KIND_ERROR     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NO_OPEN  = 2'd1,
        ERR_NO_CLOSE = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    typedef enum logic [0:0] {
        REG_DELIMITER = 1'b0,
        REG_UNUSED    = 1'b1
    } t_reg_idx;

    // one accepted input request
    typedef struct packed {
        logic [7:0] text_byte;
        logic       starts_text;
    } t_req;

    // one result
    typedef struct packed {
        logic [7:0]  out_byte;
        t_kind       kind;
        logic [15:0] element_count;
        t_err        error_code;
    } t_res;

endpackage
`default_nettype wire

// ===== sv/als_in_stage.sv =====
// input register of the splitter
`timescale 1ns / 1ps
`default_nettype none
module als_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire als_pkg::t_req i_req,
    input  wire logic          i_advance,
    output logic               o_valid,
    output als_pkg::t_req      o_req
);

    logic          r_valid;
    als_pkg::t_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule
`default_nettype wire

// ===== sv/als_parser.sv =====
// parse state, per-byte update and result register
`timescale 1ns / 1ps
`default_nettype none
module als_parser #(
    parameter int MAX_NEST   = 255,
    parameter int COUNT_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire als_pkg::t_req i_req,
    input  wire logic [7:0]    i_delimiter,
    output logic               o_advance,
    output logic               o_valid,
    input  wire logic          i_ready,
    output als_pkg::t_res      o_res
);

    localparam int NB = $clog2(MAX_NEST + 1);
    localparam logic [NB-1:0] NEST_MAX = NB'(MAX_NEST);

    logic [NB-1:0]         r_nest,   n_nest;
    logic                  r_quote,  n_quote;
    logic                  r_esc,    n_esc;
    logic                  r_acq,    n_acq;
    logic                  r_skip,   n_skip;
    logic                  r_active, n_active;
    logic [COUNT_BITS-1:0] r_count,  n_count;

    logic                  r_valid,  n_valid;
    als_pkg::t_res         r_res,    n_res;

    logic [7:0]            b;
    logic                  is_space;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] res_count;
    logic [31:0]           res_count_w;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    assign b         = i_req.text_byte;
    assign is_space  = (b == als_pkg::CH_SPACE) ||
                       ((b >= als_pkg::CH_TAB) && (b <= als_pkg::CH_CR));
    assign count_inc = r_count + COUNT_BITS'(1);
    assign res_count_w = 32'(res_count);

    always_comb begin
        n_nest    = r_nest;
        n_quote   = r_quote;
        n_esc     = r_esc;
        n_acq     = r_acq;
        n_skip    = r_skip;
        n_active  = r_active;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_res.out_byte   = 8'd0;
        n_res.kind       = als_pkg::KIND_BYTE;
        n_res.error_code = als_pkg::ERR_NONE;
        res_count = r_count;

        if (i_req.starts_text) begin
            n_nest   = '0;
            n_quote  = 1'b0;
            n_esc    = 1'b0;
            n_acq    = 1'b0;
            n_skip   = 1'b0;
            n_count  = '0;
            res_count = '0;
            if (b != als_pkg::CH_OPEN) begin
                n_active         = 1'b0;
                n_valid          = 1'b1;
                n_res.kind       = als_pkg::KIND_ERROR;
                n_res.error_code = als_pkg::ERR_NO_OPEN;
            end else begin
                n_active = 1'b1;
            end
        end else if (r_active) begin
            priority if (b == als_pkg::CH_NUL) begin
                n_active         = 1'b0;
                n_valid          = 1'b1;
                n_res.kind       = als_pkg::KIND_ERROR;
                n_res.error_code = als_pkg::ERR_NO_CLOSE;
            end else if (r_esc) begin
                n_esc          = 1'b0;
                n_valid        = !r_acq;
                n_res.out_byte = b;
            end else if (r_skip && is_space) begin
                n_valid = 1'b0;
            end else begin
                n_skip = 1'b0;
                priority if (b == als_pkg::CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (b == als_pkg::CH_QUOTE && r_nest == '0) begin
                    if (!r_quote) begin
                        n_quote    = 1'b1;
                        n_acq      = 1'b0;
                        n_valid    = 1'b1;
                        n_res.kind = als_pkg::KIND_DISCARD;
                    end else begin
                        n_quote = 1'b0;
                        n_acq   = 1'b1;
                    end
                end else if (b == als_pkg::CH_OPEN && !r_quote && r_nest >= NEST_MAX) begin
                    n_active         = 1'b0;
                    n_valid          = 1'b1;
                    n_res.kind       = als_pkg::KIND_ERROR;
                    n_res.error_code = als_pkg::ERR_OVERFLOW;
                end else if (b == als_pkg::CH_CLOSE && !r_quote && r_nest == '0) begin
                    n_active   = 1'b0;
                    n_valid    = 1'b1;
                    n_res.kind = als_pkg::KIND_ARRAY_END;
                    res_count  = count_inc;
                end else if (b != als_pkg::CH_OPEN && b != als_pkg::CH_CLOSE &&
                             b != als_pkg::CH_QUOTE && b == i_delimiter &&
                             !r_quote && r_nest == '0) begin
                    n_count    = count_inc;
                    res_count  = count_inc;
                    n_acq      = 1'b0;
                    n_skip     = 1'b1;
                    n_valid    = 1'b1;
                    n_res.kind = als_pkg::KIND_ELEM_END;
                end else begin
                    if (!r_quote && b == als_pkg::CH_OPEN) begin
                        n_nest = r_nest + NB'(1);
                    end else if (!r_quote && b == als_pkg::CH_CLOSE) begin
                        n_nest = r_nest - NB'(1);
                    end
                    n_valid        = !r_acq;
                    n_res.out_byte = b;
                end
            end
        end
        n_res.element_count = res_count_w[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nest   <= '0;
            r_quote  <= 1'b0;
            r_esc    <= 1'b0;
            r_acq    <= 1'b0;
            r_skip   <= 1'b0;
            r_active <= 1'b0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid && n_valid;
            if (i_valid) begin
                r_nest   <= n_nest;
                r_quote  <= n_quote;
                r_esc    <= n_esc;
                r_acq    <= n_acq;
                r_skip   <= n_skip;
                r_active <= n_active;
                r_count  <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_res <= n_res;
        end
    end

endmodule
`default_nettype wire

// ===== sv/array_literal_splitter.sv =====
// top level of the array literal splitter: stream ports and register port
//
// channel  direction  fields (lowest bit first)
// s_axis   in         tdata: text_byte[7:0]; tuser: starts_text
// m_axis   out        tdata: out_byte[7:0], element_count[23:8], error_code[25:24];
//                     tuser: kind[2:0]
// apb      in/out     register 0 at address 0: delimiter[7:0]
//
// one request per cycle while the result register is not stalled; a result passes through
// the input register, then the per-byte update into the result register
// reset clears parse state, pipeline valids and sets the delimiter to a comma
// a stalled result holds both registers; the input register still takes a
// request while it is empty
`timescale 1ns / 1ps
`default_nettype none
module array_literal_splitter #(
    parameter int MAX_NEST   = 255,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // text_byte[7:0]
    input  wire logic        i_s_axis_tuser,   // starts_text
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // out_byte[7:0], element_count[23:8],
                                               // error_code[25:24], zero[31:26]
    output logic [2:0]       o_m_axis_tuser,   // kind[2:0]
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    logic                    r_delim;
    logic [7:0]              r_delimiter;
    als_pkg::t_req           s_req;
    als_pkg::t_req           p_req;
    logic                    p_valid;
    logic                    advance;
    als_pkg::t_res           res;
    als_pkg::t_reg_idx       reg_idx;

    assign o_pready = 1'b1;
    assign reg_idx  = als_pkg::t_reg_idx'(i_paddr[2]);
    assign r_delim  = (reg_idx == als_pkg::REG_DELIMITER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter <= als_pkg::DELIM_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready && r_delim) begin
            r_delimiter <= i_pwdata[7:0];
        end
    end

    assign o_prdata = r_delim ? {24'd0, r_delimiter} : 32'd0;

    assign s_req.text_byte   = i_s_axis_tdata;
    assign s_req.starts_text = i_s_axis_tuser;

    als_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_req     (s_req),
        .i_advance (advance),
        .o_valid   (p_valid),
        .o_req     (p_req)
    );

    als_parser #(
        .MAX_NEST   (MAX_NEST),
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (p_valid),
        .i_req       (p_req),
        .i_delimiter (r_delimiter),
        .o_advance   (advance),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {6'd0, res.error_code, res.element_count, res.out_byte};
    assign o_m_axis_tuser = res.kind;

endmodule
`default_nettype wire

// ===== sv/als_checker.sv =====
// port checks of the array literal splitter and their bind
`timescale 1ns / 1ps
`default_nettype none
module als_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic [2:0]  o_m_axis_tuser
);

    // error code only on error results
    a_err_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != als_pkg::KIND_ERROR)
            |-> (o_m_axis_tdata[25:24] == 2'd0))
        else $error("error code on a non-error result");

    // byte field only on element bytes, top bits zero
    a_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser == als_pkg::KIND_BYTE ||
                              o_m_axis_tdata[7:0] == 8'd0) &&
                             o_m_axis_tdata[31:26] == 6'd0))
        else $error("byte field set on a control result");

    // kind within its codes
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser <= als_pkg::KIND_ERROR))
        else $error("kind out of range");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
            |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind array_literal_splitter als_checker u_als_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

// ===== tb/sv/tb_array_literal_splitter.sv =====
// testbench for the array literal splitter: directed and random literals against a parser model
`timescale 1ns / 1ps
module tb_array_literal_splitter;
    import als_pkg::*;

    localparam int NEST_LIMIT   = 255;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        i_psel          = 1'b0;
    logic        i_penable       = 1'b0;
    logic        i_pwrite        = 1'b0;
    logic [2:0]  i_paddr         = '0;
    logic [31:0] i_pwdata        = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    // parser model state
    logic [7:0]  delim_byte = DELIM_RESET;
    int          nest_lvl;
    bit          quoted;
    bit          esc_pend;
    bit          closed_quote;
    bit          skip_ws;
    bit          parsing;
    logic [15:0] elems_done;

    t_res        res_q[$];
    t_res        seen_res;
    t_res        want_res;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          err_count = 0;
    int          req_count = 0;
    int          res_count = 0;

    array_literal_splitter #(
        .MAX_NEST   (NEST_LIMIT),
        .COUNT_BITS (16)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("array_literal_splitter test failed");
        $finish;
    end

    function automatic t_res make_res(t_kind k, logic [7:0] b, t_err e, logic [15:0] cnt);
        t_res r;
        r.out_byte      = (k == KIND_BYTE) ? b : 8'h00;
        r.kind          = k;
        r.element_count = cnt;
        r.error_code    = (k == KIND_ERROR) ? e : ERR_NONE;
        return r;
    endfunction

    function automatic void clear_parse();
        nest_lvl     = 0;
        quoted       = 1'b0;
        esc_pend     = 1'b0;
        closed_quote = 1'b0;
        skip_ws      = 1'b0;
        parsing      = 1'b0;
        elems_done   = '0;
    endfunction

    // element byte, held back after a closing quote
    function automatic bit text_result(input logic [7:0] b, output t_res r);
        r = make_res(KIND_BYTE, b, ERR_NONE, elems_done);
        return !closed_quote;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input bit first, output t_res r);
        r = '0;
        if (first) begin
            clear_parse();
            if (b != CH_OPEN) begin
                r = make_res(KIND_ERROR, 8'h00, ERR_NO_OPEN, elems_done);
                return 1'b1;
            end
            parsing = 1'b1;
            return 1'b0;
        end
        if (!parsing)
            return 1'b0;
        if (b == CH_NUL) begin
            parsing = 1'b0;
            r = make_res(KIND_ERROR, 8'h00, ERR_NO_CLOSE, elems_done);
            return 1'b1;
        end
        if (esc_pend) begin
            esc_pend = 1'b0;
            return text_result(b, r);
        end
        if (skip_ws) begin
            if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                return 1'b0;
            skip_ws = 1'b0;
        end
        if (b == CH_BSLASH) begin
            esc_pend = 1'b1;
            return 1'b0;
        end
        if (b == CH_QUOTE) begin
            if (nest_lvl != 0)
                return text_result(b, r);
            if (!quoted) begin
                quoted       = 1'b1;
                closed_quote = 1'b0;
                r = make_res(KIND_DISCARD, 8'h00, ERR_NONE, elems_done);
                return 1'b1;
            end
            quoted       = 1'b0;
            closed_quote = 1'b1;
            return 1'b0;
        end
        if (b == CH_OPEN) begin
            if (!quoted) begin
                if (nest_lvl >= NEST_LIMIT) begin
                    parsing = 1'b0;
                    r = make_res(KIND_ERROR, 8'h00, ERR_OVERFLOW, elems_done);
                    return 1'b1;
                end
                nest_lvl++;
            end
            return text_result(b, r);
        end
        if (b == CH_CLOSE) begin
            if (!quoted) begin
                if (nest_lvl == 0) begin
                    parsing = 1'b0;
                    r = make_res(KIND_ARRAY_END, 8'h00, ERR_NONE, elems_done + 16'd1);
                    return 1'b1;
                end
                nest_lvl--;
            end
            return text_result(b, r);
        end
        if (b == delim_byte && !quoted && nest_lvl == 0) begin
            elems_done++;
            closed_quote = 1'b0;
            skip_ws      = 1'b1;
            r = make_res(KIND_ELEM_END, 8'h00, ERR_NONE, elems_done);
            return 1'b1;
        end
        return text_result(b, r);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_res.out_byte      = o_m_axis_tdata[7:0];
            seen_res.element_count = o_m_axis_tdata[23:8];
            seen_res.error_code    = t_err'(o_m_axis_tdata[25:24]);
            seen_res.kind          = t_kind'(o_m_axis_tuser);
            res_count++;
            if (res_q.size() == 0) begin
                note_mismatch("unexpected result", 32'h0, o_m_axis_tdata);
            end else begin
                want_res = res_q.pop_front();
                if (seen_res.kind !== want_res.kind)
                    note_mismatch("kind", want_res.kind, seen_res.kind);
                if (seen_res.out_byte !== want_res.out_byte)
                    note_mismatch("out_byte", want_res.out_byte, seen_res.out_byte);
                if (seen_res.element_count !== want_res.element_count)
                    note_mismatch("element_count", want_res.element_count,
                                  seen_res.element_count);
                if (seen_res.error_code !== want_res.error_code)
                    note_mismatch("error_code", want_res.error_code, seen_res.error_code);
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_item(input logic [7:0] b, input bit first);
        t_res r;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= first;
        do @(posedge i_clk); while (!o_s_axis_tready);
        req_count++;
        if (parse_byte(b, first, r))
            res_q.push_back(r);
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        while (res_q.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (res_q.size() != 0) begin
            err_count += res_q.size();
            $display("%0t ns: %0d expected results never arrived", $time, res_q.size());
            res_q.delete();
        end
    endtask

    task automatic write_delimiter(input logic [7:0] value);
        logic [31:0] rd;
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {REG_DELIMITER, 2'b00};
        i_pwdata  <= {24'h0, value};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        delim_byte = value;
        // read back
        i_pwrite  <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rd = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        if (rd[7:0] !== value)
            note_mismatch("delimiter read-back", value, rd[7:0]);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_OPEN || b == CH_CLOSE || b == CH_BSLASH || b == CH_QUOTE ||
               b == delim_byte);
        return b;
    endfunction

    function automatic logic [7:0] space_byte();
        if ($urandom_range(0, 2) == 0)
            return CH_SPACE;
        return 8'(CH_TAB + $urandom_range(0, 4));
    endfunction

    task automatic send_plain(input int n);
        repeat (n) send_item(plain_byte(), 1'b0);
    endtask

    task automatic send_element(input logic [7:0] sep);
        int depth;
        case ($urandom_range(0, 5))
            0: send_plain($urandom_range(1, 4));
            1: begin
                // quoted text, with junk before and after the quotes
                send_plain($urandom_range(0, 2));
                send_item(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 4))
                        0: send_item(sep, 1'b0);
                        1: send_item($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE, 1'b0);
                        2: begin
                            send_item(CH_BSLASH, 1'b0);
                            send_item(CH_QUOTE, 1'b0);
                        end
                        3: send_item(space_byte(), 1'b0);
                        default: send_plain(1);
                    endcase
                end
                send_item(CH_QUOTE, 1'b0);
                send_plain($urandom_range(0, 2));
            end
            2: begin
                depth = $urandom_range(1, 3);
                repeat (depth) begin
                    send_item(CH_OPEN, 1'b0);
                    send_plain($urandom_range(0, 2));
                end
                if ($urandom_range(0, 1))
                    send_item(CH_QUOTE, 1'b0);
                if ($urandom_range(0, 1))
                    send_item(sep, 1'b0);
                repeat (depth) send_item(CH_CLOSE, 1'b0);
            end
            3: begin
                send_plain($urandom_range(0, 2));
                send_item(CH_BSLASH, 1'b0);
                send_item(8'($urandom_range(1, 255)), 1'b0);
                send_plain($urandom_range(0, 2));
            end
            4: ;
            default: begin
                send_plain($urandom_range(1, 2));
                send_item(space_byte(), 1'b0);
                send_plain($urandom_range(1, 2));
            end
        endcase
    endtask

    task automatic send_literal();
        int         n_elem;
        logic [7:0] sep;
        // a delimiter that is a special byte cannot split, so separate with a comma
        if (delim_byte == CH_NUL || delim_byte == CH_OPEN || delim_byte == CH_CLOSE ||
            delim_byte == CH_BSLASH || delim_byte == CH_QUOTE)
            sep = DELIM_RESET;
        else
            sep = delim_byte;
        send_item(CH_OPEN, 1'b1);
        n_elem = $urandom_range(0, 5);
        for (int e = 0; e < n_elem; e++) begin
            if (e != 0) begin
                send_item(sep, 1'b0);
                repeat ($urandom_range(0, 2)) send_item(space_byte(), 1'b0);
            end
            send_element(sep);
        end
        case ($urandom_range(0, 9))
            0: send_item(CH_NUL, 1'b0);
            1: send_item(8'($urandom_range(0, 255)), 1'b1);
            default: send_item(CH_CLOSE, 1'b0);
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(8'hFF, 1'b1);       // start byte that is not a brace
        send_item(CH_NUL, 1'b1);
        send_item(8'h61, 1'b0);       // ignored while idle
        send_item(CH_OPEN, 1'b1);
        send_item(8'h61, 1'b0);
        send_item(DELIM_RESET, 1'b0);
        send_item(CH_SPACE, 1'b0);    // whitespace after a delimiter
        send_item(CH_TAB, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(CH_QUOTE, 1'b0);    // opening quote discards the element so far
        send_item(DELIM_RESET, 1'b0); // no split inside quotes
        send_item(CH_QUOTE, 1'b0);
        send_item(8'h78, 1'b0);       // held back after the closing quote
        send_item(DELIM_RESET, 1'b0);
        send_item(CH_OPEN, 1'b0);
        send_item(CH_QUOTE, 1'b0);    // quote below the top level
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_CLOSE, 1'b0);    // escaped brace
        send_item(CH_CLOSE, 1'b0);
        send_item(CH_CLOSE, 1'b0);
        send_item(CH_OPEN, 1'b1);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_NUL, 1'b0);      // end of text right after an escape
        send_item(CH_OPEN, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(CH_OPEN, 1'b1);     // restart in the middle of a literal
        send_item(CH_NUL, 1'b0);
        wait_idle();
    endtask

    task automatic test_nesting_overflow();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(CH_OPEN, 1'b1);
        repeat (NEST_LIMIT) send_item(CH_OPEN, 1'b0);
        send_item(CH_OPEN, 1'b0);
        send_item(CH_CLOSE, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_literals(input logic [7:0] delim, input int idle,
                                        input int stall, input int n_items);
        int stop_at;
        if (delim != delim_byte)
            write_delimiter(delim);
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = req_count + n_items;
        while (req_count < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_literal();
        end
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_nesting_overflow();
        test_random_literals(DELIM_RESET, 0, 0, 250);
        test_random_literals(8'hFF, 60, 0, 250);
        test_random_literals(8'h3B, 0, 60, 250);
        test_random_literals(CH_NUL, 23, 23, 200);
        test_random_literals(CH_QUOTE, 23, 23, 200);
        $display("sent %0d requests and checked %0d results", req_count, res_count);
        $display("covered start errors, early end of text, nesting overflow, "
                 , "quoted and escaped elements under five delimiters");
        if (err_count == 0) begin
            $display("array_literal_splitter test passed");
        end else begin
            $display("array_literal_splitter test failed");
        end
        $finish;
    end

endmodule
